// File: src/glte_pkg.sv
// ----------------------------------------------------------------------------
// glte_pkg: shared types and constants of the geodetic to ENU converter
// Fixed-point constants (Q60 angles and ratios), the CORDIC arctangent table,
// the queued fix word and the multiplier request and response words.
// ----------------------------------------------------------------------------
package glte_pkg;

  localparam logic signed [63:0] ONE_Q60      = 64'sh1000_0000_0000_0000;
  localparam logic signed [63:0] THREE_Q60    = 64'sh3000_0000_0000_0000;
  localparam logic signed [63:0] PI_Q60       = 64'sh3243_F6A8_885A_308D;
  localparam logic signed [63:0] HALF_PI_Q60  = 64'sh1921_FB54_442D_1846;
  localparam logic signed [63:0] QUART_PI_Q60 = 64'sh0C90_FDAA_2216_8C23;
  localparam logic signed [63:0] GAIN_Q60     = 64'sd700114967507363238;
  localparam logic signed [63:0] ECC2_Q60     = 64'sd7718094650642178;
  localparam logic signed [63:0] ONE_M_ECC2   = ONE_Q60 - ECC2_Q60;
  localparam logic signed [63:0] SEMI_QMM     = 64'sd25512548000;
  localparam logic signed [63:0] SAT_MAX      = 64'sd2147483647;
  localparam logic signed [63:0] SAT_MIN      = -64'sd2147483648;

  // Degree (1e-7) to radian scaling split into quotient and remainder.
  localparam logic [63:0] DEG7_TURN   = 64'd1800000000;
  localparam logic [31:0] DEG7_TURN32 = 32'd1800000000;
  localparam logic [63:0] RAD_Q       = 64'(PI_Q60) / DEG7_TURN;
  localparam logic [63:0] RAD_R       = 64'(PI_Q60) % DEG7_TURN;
  // Reciprocal of the half-turn count, scaled by 2^63.
  localparam logic [63:0] RAD_RECIP   = (64'd1 << 63) / DEG7_TURN;

  localparam int ATAN_DEPTH = 48;
  localparam int ATAN_AW    = $clog2(ATAN_DEPTH);

  typedef logic signed [63:0] atan_tab_t [ATAN_DEPTH];

  function automatic atan_tab_t build_atan();
    atan_tab_t tab;
    logic signed [63:0] sum;
    logic signed [63:0] term;
    int k;
    int sh;
    tab[0] = QUART_PI_Q60;
    for (int i = 1; i < ATAN_DEPTH; i++) begin
      sum = 64'sd0;
      k   = 0;
      sh  = 60 - i;
      while (sh >= 0) begin
        term = $signed((64'd1 << sh) / 64'(2 * k + 1));
        sum  = (k % 2 == 1) ? sum - term : sum + term;
        k    = k + 1;
        sh   = 60 - i * (2 * k + 1);
      end
      tab[i] = sum;
    end
    return tab;
  endfunction

  localparam atan_tab_t ATAN_TAB = build_atan();

  typedef struct packed {
    logic [30:0] latitude;
    logic [31:0] longitude;
    logic [26:0] altitude;
    logic        good;
  } fix_t;

  typedef struct packed {
    logic               go;
    logic signed [63:0] a;
    logic signed [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic signed [63:0] q60;
    logic [63:0]        lo;
  } mul_rsp_t;

endpackage

// File: src/glte_front.sv
// ----------------------------------------------------------------------------
// glte_front: input side of the converter
// Holds the fix level register and tags each accepted fix as good or not
// before it enters the queue.
// ----------------------------------------------------------------------------
module glte_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic [2:0]            cfg_data,
  input  logic                  in_take,
  input  logic [30:0]           latitude,
  input  logic [31:0]           longitude,
  input  logic [26:0]           altitude,
  input  logic [2:0]            fix_quality,
  output logic                  push,
  output glte_pkg::fix_t        entry
);

  logic [2:0] min_fix_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_fix_level <= 3'd2;
    end else if (cfg_valid) begin
      min_fix_level <= cfg_data;
    end
  end

  assign push            = in_take;
  assign entry.latitude  = latitude;
  assign entry.longitude = longitude;
  assign entry.altitude  = altitude;
  assign entry.good      = (fix_quality >= min_fix_level);

endmodule

// File: src/glte_queue.sv
// ----------------------------------------------------------------------------
// glte_queue: short fix queue between the front and the back
// Two entries, so the front keeps taking words while the back is busy.
// ----------------------------------------------------------------------------
module glte_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  glte_pkg::fix_t wr_data,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output glte_pkg::fix_t head
);

  localparam int DEPTH = 2;
  localparam int AW    = $clog2(DEPTH);

  glte_pkg::fix_t  mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [AW:0]     count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        mem[wr_ptr] <= wr_data;
        wr_ptr      <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  assign full      = (count == (AW+1)'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

endmodule

// File: src/glte_mul.sv
// ----------------------------------------------------------------------------
// glte_mul: shared 64 x 64 multiplier
// Four 32 x 32 partial products accumulated in turn, then a Q60 scaling with
// magnitude saturation. The low product word serves the unsigned scaling.
// ----------------------------------------------------------------------------
module glte_mul (
  input  logic               clk,
  input  logic               rst,
  input  glte_pkg::mul_req_t req,
  output glte_pkg::mul_rsp_t rsp
);

  logic [63:0]  ua;
  logic [63:0]  ub;
  logic         neg;
  logic [127:0] acc;
  logic [1:0]   cnt;
  logic         busy;
  logic         fin;

  logic [31:0]  a_part;
  logic [31:0]  b_part;
  logic [63:0]  pp;
  logic [1:0]   pos;
  logic [127:0] addend;
  logic         sat;
  logic [63:0]  mag;

  always_comb begin
    a_part = cnt[1] ? ua[63:32] : ua[31:0];
    b_part = cnt[0] ? ub[63:32] : ub[31:0];
    pp     = a_part * b_part;
    pos    = {1'b0, cnt[1]} + {1'b0, cnt[0]};
    addend = {64'd0, pp} << {pos, 5'd0};
    sat    = |acc[127:123];
    mag    = sat ? 64'h7FFF_FFFF_FFFF_FFFF : {1'b0, acc[122:60]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      fin      <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= !req.go && !busy && fin;
      if (req.go) begin
        ua   <= req.a[63] ? 64'(-req.a) : 64'(req.a);
        ub   <= req.b[63] ? 64'(-req.b) : 64'(req.b);
        neg  <= req.a[63] ^ req.b[63];
        acc  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        acc <= acc + addend;
        cnt <= cnt + 1'b1;
        if (cnt == 2'd3) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin      <= 1'b0;
        rsp.q60  <= neg ? -$signed(mag) : $signed(mag);
        rsp.lo   <= acc[63:0];
      end
    end
  end

endmodule

// File: src/glte_back.sv
// ----------------------------------------------------------------------------
// glte_back: conversion sequencer
// Scales both angles to radians, runs CORDIC for sine and cosine, then steps
// through the ECEF and ENU products on the shared multiplier. Captures the
// reference on the first good fix and holds the result word for the output.
// ----------------------------------------------------------------------------
module glte_back #(
  parameter int CORDIC_ITERATIONS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  glte_pkg::fix_t     q_head,
  output logic               q_pop,
  output glte_pkg::mul_req_t mul_req,
  input  glte_pkg::mul_rsp_t mul_rsp,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [31:0]        east,
  output logic [31:0]        north,
  output logic [31:0]        up,
  output logic               valid_res
);

  localparam int CW     = $clog2(CORDIC_ITERATIONS);
  localparam int TAB_AW = glte_pkg::ATAN_AW;

  typedef enum logic [4:0] {
    S_IDLE, S_RAD0, S_RADQ, S_RADQ_W, S_RADR, S_RADR_W, S_DIV, S_DIV_W,
    S_REM, S_FIX, S_RAD4, S_RAD5, S_COR, S_CEND, S_MUL, S_MUL_W, S_FIN
  } state_t;

  typedef enum logic [4:0] {
    M_SLSQ, M_ESL, M_NSQ, M_NWT, M_NUPD, M_RN, M_RC, M_X, M_Y, M_ZB, M_Z,
    M_E0, M_E1, M_N0, M_N1, M_N2, M_N3, M_N4, M_U0, M_U1, M_U2, M_U3, M_U4
  } mstep_t;

  state_t  state;
  mstep_t  mstep;

  logic [30:0] lat;
  logic [31:0] lon;
  logic [26:0] alt;
  logic        ang_sel;
  logic [31:0] mag;
  logic        neg;
  logic [63:0] mq;
  logic [63:0] num;
  logic [63:0] remr;
  logic [31:0] quot;
  logic signed [63:0] ang;
  logic signed [63:0] cx, cy, cz;
  logic        flip;
  logic [CW-1:0] cc;
  logic [2:0]  k;

  logic signed [63:0] sl, cl, so, co;
  logic signed [63:0] w, inv, t, rn, rc, x, y;
  logic signed [63:0] e, n, u;
  logic signed [63:0] rsl, rcl, rso, rco;
  logic [35:0] rx, ry, rz;
  logic        reference_set;
  logic        vres;
  logic        res_valid;

  logic               slot_free;
  logic               res_load;
  logic               mul_last;
  logic               nwt_again;
  logic signed [63:0] cur_ang;
  logic signed [63:0] h;
  logic signed [63:0] dx, dy;
  logic signed [63:0] res;
  logic signed [63:0] atan_i;
  logic [63:0]        qprod;
  logic [63:0]        asum;

  function automatic logic [31:0] to_mm(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = (v + 64'sd2) >>> 2;
    if (r > glte_pkg::SAT_MAX) begin
      return 32'h7FFF_FFFF;
    end
    if (r < glte_pkg::SAT_MIN) begin
      return 32'h8000_0000;
    end
    return r[31:0];
  endfunction

  always_comb begin
    slot_free = !res_valid || !out_stall;
    q_pop     = (state == S_IDLE) && q_valid && (q_head.good || slot_free);
    res_load  = ((state == S_IDLE) && q_pop && !q_head.good) ||
                ((state == S_FIN) && slot_free);
    mul_last  = (mstep == M_U4) || ((mstep == M_Z) && !reference_set);
    nwt_again = (mstep == M_NUPD) && (k != 3'd5);
    cur_ang   = ang_sel ? {{32{lon[31]}}, lon} : {{33{lat[30]}}, lat};
    h         = {{35{alt[26]}}, alt, 2'b00};
    dx        = x - {{28{rx[35]}}, rx};
    dy        = y - {{28{ry[35]}}, ry};
    res       = mul_rsp.q60;
    atan_i    = glte_pkg::ATAN_TAB[TAB_AW'(cc)];
    qprod     = {32'd0, quot} * {32'd0, glte_pkg::DEG7_TURN32};
    asum      = mq + {32'd0, quot};
  end

  // The z difference uses the z latched for this fix.
  logic signed [63:0] z;
  logic signed [63:0] dzr;
  assign dzr = z - {{28{rz[35]}}, rz};

  always_comb begin
    mul_req.go = 1'b0;
    mul_req.a  = '0;
    mul_req.b  = '0;
    unique case (state)
      S_RADQ: begin
        mul_req.go = 1'b1;
        mul_req.a  = {32'd0, mag};
        mul_req.b  = $signed(glte_pkg::RAD_Q);
      end
      S_RADR: begin
        mul_req.go = 1'b1;
        mul_req.a  = {32'd0, mag};
        mul_req.b  = $signed(glte_pkg::RAD_R);
      end
      S_DIV: begin
        mul_req.go = 1'b1;
        mul_req.a  = {3'd0, num[63:3]};
        mul_req.b  = $signed(glte_pkg::RAD_RECIP);
      end
      S_MUL: begin
        mul_req.go = 1'b1;
        unique case (mstep)
          M_SLSQ: begin mul_req.a = sl; mul_req.b = sl; end
          M_ESL:  begin mul_req.a = glte_pkg::ECC2_Q60; mul_req.b = t; end
          M_NSQ:  begin mul_req.a = inv; mul_req.b = inv; end
          M_NWT:  begin mul_req.a = w; mul_req.b = t; end
          M_NUPD: begin mul_req.a = inv; mul_req.b = glte_pkg::THREE_Q60 - t; end
          M_RN:   begin mul_req.a = glte_pkg::SEMI_QMM; mul_req.b = inv; end
          M_RC:   begin mul_req.a = rn + h; mul_req.b = cl; end
          M_X:    begin mul_req.a = rc; mul_req.b = co; end
          M_Y:    begin mul_req.a = rc; mul_req.b = so; end
          M_ZB:   begin mul_req.a = rn; mul_req.b = glte_pkg::ONE_M_ECC2; end
          M_Z:    begin mul_req.a = t + h; mul_req.b = sl; end
          M_E0:   begin mul_req.a = rso; mul_req.b = dx; end
          M_E1:   begin mul_req.a = rco; mul_req.b = dy; end
          M_N0:   begin mul_req.a = rsl; mul_req.b = rco; end
          M_N1:   begin mul_req.a = t; mul_req.b = dx; end
          M_N2:   begin mul_req.a = rsl; mul_req.b = rso; end
          M_N3:   begin mul_req.a = t; mul_req.b = dy; end
          M_N4:   begin mul_req.a = rcl; mul_req.b = dzr; end
          M_U0:   begin mul_req.a = rcl; mul_req.b = rco; end
          M_U1:   begin mul_req.a = t; mul_req.b = dx; end
          M_U2:   begin mul_req.a = rcl; mul_req.b = rso; end
          M_U3:   begin mul_req.a = t; mul_req.b = dy; end
          M_U4:   begin mul_req.a = rsl; mul_req.b = dzr; end
          default: begin mul_req.a = '0; mul_req.b = '0; end
        endcase
      end
      default: begin
        mul_req.go = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      mstep         <= M_SLSQ;
      reference_set <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (!out_stall) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            if (q_head.good) begin
              lat     <= q_head.latitude;
              lon     <= q_head.longitude;
              alt     <= q_head.altitude;
              ang_sel <= 1'b0;
              state   <= S_RAD0;
            end else begin
              east      <= '0;
              north     <= '0;
              up        <= '0;
              valid_res <= 1'b0;
            end
          end
        end
        S_RAD0: begin
          neg   <= cur_ang[63];
          mag   <= cur_ang[63] ? 32'(-cur_ang) : cur_ang[31:0];
          state <= S_RADQ;
        end
        S_RADQ: begin
          state <= S_RADQ_W;
        end
        S_RADQ_W: begin
          if (mul_rsp.done) begin
            mq    <= mul_rsp.lo;
            state <= S_RADR;
          end
        end
        S_RADR: begin
          state <= S_RADR_W;
        end
        S_RADR_W: begin
          if (mul_rsp.done) begin
            num   <= mul_rsp.lo;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          state <= S_DIV_W;
        end
        S_DIV_W: begin
          // The reciprocal estimate is at most two below the true quotient.
          if (mul_rsp.done) begin
            quot  <= mul_rsp.q60[31:0];
            state <= S_REM;
          end
        end
        S_REM: begin
          remr  <= num - qprod;
          state <= S_FIX;
        end
        S_FIX: begin
          if (remr >= glte_pkg::DEG7_TURN) begin
            remr <= remr - glte_pkg::DEG7_TURN;
            quot <= quot + 32'd1;
          end else begin
            state <= S_RAD4;
          end
        end
        S_RAD4: begin
          ang   <= neg ? -$signed(asum) : $signed(asum);
          state <= S_RAD5;
        end
        S_RAD5: begin
          if (ang > glte_pkg::HALF_PI_Q60) begin
            cz   <= ang - glte_pkg::PI_Q60;
            flip <= 1'b1;
          end else if (ang < -glte_pkg::HALF_PI_Q60) begin
            cz   <= ang + glte_pkg::PI_Q60;
            flip <= 1'b1;
          end else begin
            cz   <= ang;
            flip <= 1'b0;
          end
          cx    <= glte_pkg::GAIN_Q60;
          cy    <= '0;
          cc    <= '0;
          state <= S_COR;
        end
        S_COR: begin
          if (!cz[63]) begin
            cx <= cx - (cy >>> cc);
            cy <= cy + (cx >>> cc);
            cz <= cz - atan_i;
          end else begin
            cx <= cx + (cy >>> cc);
            cy <= cy - (cx >>> cc);
            cz <= cz + atan_i;
          end
          cc <= cc + 1'b1;
          if (cc == CW'(CORDIC_ITERATIONS - 1)) begin
            state <= S_CEND;
          end
        end
        S_CEND: begin
          if (!ang_sel) begin
            sl      <= flip ? -cy : cy;
            cl      <= flip ? -cx : cx;
            ang_sel <= 1'b1;
            state   <= S_RAD0;
          end else begin
            so    <= flip ? -cy : cy;
            co    <= flip ? -cx : cx;
            inv   <= glte_pkg::ONE_Q60;
            k     <= '0;
            mstep <= M_SLSQ;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_MUL_W;
        end
        S_MUL_W: begin
          if (mul_rsp.done) begin
            state <= mul_last ? S_FIN : S_MUL;
            mstep <= nwt_again ? M_NSQ : mstep_t'(mstep + 5'd1);
            case (mstep)
              M_SLSQ: t <= res;
              M_ESL:  w <= glte_pkg::ONE_Q60 - res;
              M_NSQ:  t <= res;
              M_NWT:  t <= res;
              M_NUPD: begin
                inv <= res >>> 1;
                if (k != 3'd5) begin
                  k <= k + 1'b1;
                end
              end
              M_RN:   rn <= res;
              M_RC:   rc <= res;
              M_X:    x  <= res;
              M_Y:    y  <= res;
              M_ZB:   t  <= res;
              M_Z: begin
                z <= res;
                if (!reference_set) begin
                  reference_set <= 1'b1;
                  rx    <= x[35:0];
                  ry    <= y[35:0];
                  rz    <= res[35:0];
                  rsl   <= sl;
                  rcl   <= cl;
                  rso   <= so;
                  rco   <= co;
                  e     <= '0;
                  n     <= '0;
                  u     <= '0;
                  vres  <= 1'b1;
                end
              end
              M_E0:   e <= -res;
              M_E1:   e <= e + res;
              M_N0:   t <= res;
              M_N1:   n <= -res;
              M_N2:   t <= res;
              M_N3:   n <= n - res;
              M_N4:   n <= n + res;
              M_U0:   t <= res;
              M_U1:   u <= res;
              M_U2:   t <= res;
              M_U3:   u <= u + res;
              M_U4: begin
                u     <= u + res;
                vres  <= 1'b1;
              end
              default: t <= t;
            endcase
          end
        end
        S_FIN: begin
          if (slot_free) begin
            east      <= to_mm(e);
            north     <= to_mm(n);
            up        <= to_mm(u);
            valid_res <= vres;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_valid = res_valid;

endmodule

// File: src/geodetic_lla_to_enu.sv
// ----------------------------------------------------------------------------
// geodetic_lla_to_enu: GNSS fix to local east/north/up converter (WGS84)
// Converts latitude, longitude and ellipsoid height to ENU offsets in mm from
// a reference latched on the first fix of sufficient quality.
// ----------------------------------------------------------------------------
// Usage: fixes enter on the input channel (in_valid/in_stall); each one gives
// exactly one result word on the output channel (out_valid/out_stall). The
// cfg channel writes the minimum fix level and is always ready; write it only
// while the block is idle.
// A two-word queue sits behind the input, so fixes are taken while the back
// end works. A fix below the level is answered from the idle state and
// returns zeros with valid_res low. A good fix runs 38 products on the
// shared 64-bit multiplier, plus three that scale each angle to radians,
// and two CORDIC passes; the reference capture fix stops after the ECEF
// products and returns zeros with valid_res high.
// Reset clears the reference, empties the queue and loads a fix level of 2.
// While out_stall is high the result word holds; once the queue is full,
// in_stall rises.
// ----------------------------------------------------------------------------
module geodetic_lla_to_enu #(
  parameter int CORDIC_ITERATIONS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [30:0] latitude,
  input  logic [31:0] longitude,
  input  logic [26:0] altitude,
  input  logic [2:0]  fix_quality,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] east,
  output logic [31:0] north,
  output logic [31:0] up,
  output logic        valid_res
);

  logic               push;
  glte_pkg::fix_t     entry;
  glte_pkg::fix_t     head;
  logic               q_full;
  logic               q_valid;
  logic               q_pop;
  glte_pkg::mul_req_t mul_req;
  glte_pkg::mul_rsp_t mul_rsp;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;

  glte_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .in_take     (in_valid && !q_full),
    .latitude    (latitude),
    .longitude   (longitude),
    .altitude    (altitude),
    .fix_quality (fix_quality),
    .push        (push),
    .entry       (entry)
  );

  glte_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_data   (entry),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (head)
  );

  glte_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  glte_back #(
    .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (head),
    .q_pop     (q_pop),
    .mul_req   (mul_req),
    .mul_rsp   (mul_rsp),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .east      (east),
    .north     (north),
    .up        (up),
    .valid_res (valid_res)
  );

endmodule
